// ----- hdl/tchd_pkg.sv -----
// Shared types and constants of the full-rate traffic burst demapper.
package tchd_pkg;

  localparam int TAG_BITS_DEF   = 16;
  localparam int FN_BITS        = 22;
  localparam int TS_BITS        = 3;
  localparam int SLOT_BITS      = 2;
  localparam int GRP_LEN        = 4;
  localparam int M_BITS         = 5;
  localparam int REM_BITS       = 6;
  localparam int MF_LEN         = 26;
  localparam int SACCH_FN_EVEN  = 12;
  localparam int SACCH_FN_ODD   = 25;
  localparam int TRAFFIC_SPLIT  = 13;

  // fn / 26 as (fn * RECIP) >> RECIP_SHIFT, low by at most one
  localparam int RECIP_BITS     = 23;
  localparam int RECIP_SHIFT    = 27;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((64'd1 << RECIP_SHIFT) / MF_LEN);
  localparam int Q_BITS         = FN_BITS + RECIP_BITS - RECIP_SHIFT;

  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int REG_IDX_BITS   = CFG_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_TIMESLOT = '0;

  typedef struct packed {
    logic                 sacch;
    logic [SLOT_BITS-1:0] slot;
    logic                 steal;
    logic [FN_BITS-1:0]   fn;
  } tchd_entry_t;

  localparam int ENTRY_BITS = 1 + SLOT_BITS + 1 + FN_BITS;

  typedef struct packed {
    logic busy;
    logic pop;
    logic rel;
  } tchd_back_st_t;

endpackage

// ----- hdl/tchd_ifs.sv -----
// Burst input and result channel interfaces.
interface tchd_in_if #(parameter int TAG_BITS = tchd_pkg::TAG_BITS_DEF) ();
  import tchd_pkg::*;
  logic                valid;
  logic                ready;
  logic [FN_BITS-1:0]  tdma_fn;
  logic [TS_BITS-1:0]  burst_timeslot;
  logic                steal_bit_left;
  logic                steal_bit_right;
  logic [TAG_BITS-1:0] burst_tag;

  modport source (output valid, tdma_fn, burst_timeslot, steal_bit_left,
                  steal_bit_right, burst_tag, input ready);
  modport sink (input valid, tdma_fn, burst_timeslot, steal_bit_left,
                steal_bit_right, burst_tag, output ready);
endinterface

interface tchd_out_if #(parameter int TAG_BITS = tchd_pkg::TAG_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] out_tag;
  logic                to_control;
  logic                from_sacch;
  logic                last;

  modport source (output valid, out_tag, to_control, from_sacch, last, input ready);
  modport sink (input valid, out_tag, to_control, from_sacch, last, output ready);
endinterface

// ----- hdl/tchd_front.sv -----
// Front end: burst capture, frame number mod 26 and slot classification.
module tchd_front #(
  parameter int TAG_BITS = tchd_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tchd_pkg::TS_BITS-1:0] timeslot,
  tchd_in_if.sink                      in_ch,
  input  logic                         q_full,
  output logic                         q_push,
  output tchd_pkg::tchd_entry_t        q_entry,
  output logic [TAG_BITS-1:0]          q_tag
);
  import tchd_pkg::*;

  logic                          s1_v_r;
  logic                          s1_keep_r;
  logic                          s1_steal_r;
  logic [FN_BITS-1:0]            s1_fn_r;
  logic [TAG_BITS-1:0]           s1_tag_r;
  logic [Q_BITS-1:0]             s1_q_r;
  logic [FN_BITS+RECIP_BITS-1:0] prod;
  logic [FN_BITS:0]              q26;
  logic [FN_BITS:0]              diff;
  logic [REM_BITS-1:0]           r0;
  logic                          ge;
  logic [M_BITS-1:0]             m;
  logic [M_BITS-1:0]             mt;
  logic [M_BITS-1:0]             f;
  logic [SLOT_BITS-1:0]          q_lo;
  logic                          sacch_hit;
  logic                          keep;
  logic                          s1_go;

  assign prod = (FN_BITS+RECIP_BITS)'(in_ch.tdma_fn) * (FN_BITS+RECIP_BITS)'(RECIP);

  assign q26  = (FN_BITS+1)'(s1_q_r) * (FN_BITS+1)'(MF_LEN);
  assign diff = {1'b0, s1_fn_r} - q26;
  assign r0   = diff[REM_BITS-1:0];
  assign ge   = r0 >= REM_BITS'(MF_LEN);
  assign m    = ge ? M_BITS'(r0 - REM_BITS'(MF_LEN)) : M_BITS'(r0);
  assign q_lo = s1_q_r[SLOT_BITS-1:0] + SLOT_BITS'(ge);
  assign mt   = m - M_BITS'(TRAFFIC_SPLIT);
  assign f    = timeslot[0] ? M_BITS'(SACCH_FN_ODD) : M_BITS'(SACCH_FN_EVEN);

  assign sacch_hit = (m == M_BITS'(SACCH_FN_EVEN)) || (m == M_BITS'(SACCH_FN_ODD));
  assign keep      = s1_keep_r && (!sacch_hit || (m == f));

  assign s1_go       = !s1_v_r || !keep || !q_full;
  assign in_ch.ready = s1_go;
  assign q_push      = s1_v_r && keep && !q_full;

  always_comb begin
    q_entry.sacch = sacch_hit;
    q_entry.steal = s1_steal_r;
    q_entry.fn    = s1_fn_r;
    if (sacch_hit) begin
      q_entry.slot = q_lo - timeslot[TS_BITS-1:1];
    end else if (m < M_BITS'(TRAFFIC_SPLIT)) begin
      q_entry.slot = m[SLOT_BITS-1:0];
    end else begin
      q_entry.slot = mt[SLOT_BITS-1:0];
    end
  end

  assign q_tag = s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_ch.valid) begin
      s1_keep_r  <= in_ch.burst_timeslot == timeslot;
      s1_steal_r <= in_ch.steal_bit_left && in_ch.steal_bit_right;
      s1_fn_r    <= in_ch.tdma_fn;
      s1_tag_r   <= in_ch.burst_tag;
      s1_q_r     <= prod[FN_BITS+RECIP_BITS-1:RECIP_SHIFT];
    end
  end

endmodule

// ----- hdl/tchd_fifo.sv -----
// Short queue between the front and back ends.
module tchd_fifo #(
  parameter int WIDTH = tchd_pkg::ENTRY_BITS,
  parameter int DEPTH = tchd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH+1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign empty   = count_r == '0;
  assign full    = count_r == CNT_BITS'(DEPTH);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/tchd_back.sv -----
// Back end: group stores, release check and result sequencing.
module tchd_back #(
  parameter int TAG_BITS = tchd_pkg::TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  tchd_pkg::tchd_entry_t q_entry,
  input  logic [TAG_BITS-1:0]   q_tag,
  output logic                  q_pop,
  tchd_out_if.source            out_ch,
  output tchd_pkg::tchd_back_st_t st
);
  import tchd_pkg::*;

  logic [FN_BITS-1:0]   tfrm_r [GRP_LEN];
  logic [FN_BITS-1:0]   sfrm_r [GRP_LEN];
  logic [TAG_BITS-1:0]  ttag_r [GRP_LEN];
  logic [TAG_BITS-1:0]  stag_r [GRP_LEN];
  logic                 stolen_r;
  logic                 busy_r;
  logic [SLOT_BITS-1:0] cnt_r;
  logic                 grp_sacch_r;
  logic                 grp_ctl_r;
  logic                 out_valid_r;
  logic [TAG_BITS-1:0]  out_tag_r;
  logic                 out_ctl_r;
  logic                 out_sacch_r;
  logic                 out_last_r;

  logic [FN_BITS-1:0]   frm [GRP_LEN];
  logic [FN_BITS:0]     step;
  logic                 chain_ok;
  logic                 out_load;
  logic                 done_now;
  logic                 rel;

  assign out_load = busy_r && (!out_valid_r || out_ch.ready);
  assign done_now = out_load && (cnt_r == SLOT_BITS'(GRP_LEN-1));
  assign q_pop    = q_valid && (!busy_r || done_now);

  assign step = q_entry.sacch ? (FN_BITS+1)'(MF_LEN) : (FN_BITS+1)'(1);

  always_comb begin
    for (int j = 0; j < GRP_LEN-1; j++) begin
      frm[j] = q_entry.sacch ? sfrm_r[j] : tfrm_r[j];
    end
    frm[GRP_LEN-1] = q_entry.fn;
    chain_ok = 1'b1;
    for (int j = 1; j < GRP_LEN; j++) begin
      if ({1'b0, frm[j]} != {1'b0, frm[j-1]} + step) begin
        chain_ok = 1'b0;
      end
    end
  end

  assign rel = q_pop && (q_entry.slot == SLOT_BITS'(GRP_LEN-1)) && chain_ok;

  assign st.busy = busy_r;
  assign st.pop  = q_pop;
  assign st.rel  = rel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      stolen_r    <= 1'b0;
      out_valid_r <= 1'b0;
      grp_sacch_r <= 1'b0;
      grp_ctl_r   <= 1'b0;
      for (int j = 0; j < GRP_LEN; j++) begin
        tfrm_r[j] <= '0;
        sfrm_r[j] <= '0;
      end
    end else begin
      if (rel) begin
        busy_r      <= 1'b1;
        cnt_r       <= '0;
        grp_sacch_r <= q_entry.sacch;
        grp_ctl_r   <= q_entry.sacch || stolen_r || q_entry.steal;
      end else begin
        if (done_now) begin
          busy_r <= 1'b0;
        end
        if (out_load) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (q_pop) begin
        if (q_entry.sacch) begin
          sfrm_r[q_entry.slot] <= q_entry.fn;
        end else begin
          tfrm_r[q_entry.slot] <= q_entry.fn;
          stolen_r <= rel ? 1'b0 : (stolen_r || q_entry.steal);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_entry.sacch) begin
        stag_r[q_entry.slot] <= q_tag;
      end else begin
        ttag_r[q_entry.slot] <= q_tag;
      end
    end
    if (out_load) begin
      out_tag_r   <= grp_sacch_r ? stag_r[cnt_r] : ttag_r[cnt_r];
      out_ctl_r   <= grp_ctl_r;
      out_sacch_r <= grp_sacch_r;
      out_last_r  <= cnt_r == SLOT_BITS'(GRP_LEN-1);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_tag    = out_tag_r;
  assign out_ch.to_control = out_ctl_r;
  assign out_ch.from_sacch = out_sacch_r;
  assign out_ch.last       = out_last_r;

endmodule

// ----- hdl/tch_full_rate_burst_demapper_unit.sv -----
// Top level of the full-rate traffic and SACCH burst demapper.
// A taken burst passes the front-end register and the queue; a released group leaves through the output register.
// Throughput: one burst per cycle while the queue has room. A released group holds the
// back end while its four results leave the output register, one per unstalled cycle.
// Reset: synchronous active-low; clears queue, frame stores, stolen flag and timeslot.
// Tag stores are not cleared.
module tch_full_rate_burst_demapper_unit #(
  parameter int TAG_BITS = tchd_pkg::TAG_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tchd_in_if.sink                            in_ch,
  tchd_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tchd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [tchd_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [tchd_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import tchd_pkg::*;

  localparam int ENTRY_W = ENTRY_BITS + TAG_BITS;

  logic [TS_BITS-1:0]               timeslot_r;
  logic [REG_IDX_BITS-1:0]          reg_idx;
  logic                             q_push;
  logic                             q_pop;
  logic                             q_full;
  logic                             q_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  tchd_entry_t                      push_entry;
  tchd_entry_t                      pop_entry;
  logic [TAG_BITS-1:0]              push_tag;
  logic [TAG_BITS-1:0]              pop_tag;
  logic [ENTRY_W-1:0]               rd_word;
  tchd_back_st_t                    st;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeslot_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_TIMESLOT) begin
      timeslot_r <= pwdata[TS_BITS-1:0];
    end
  end

  assign prdata = (reg_idx == REG_TIMESLOT) ? CFG_DATA_BITS'(timeslot_r) : '0;

  tchd_front #(.TAG_BITS(TAG_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .timeslot (timeslot_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry),
    .q_tag    (push_tag)
  );

  tchd_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({push_entry, push_tag}),
    .pop     (q_pop),
    .rd_data (rd_word),
    .empty   (q_empty),
    .full    (q_full),
    .count   (q_count)
  );

  assign pop_entry = rd_word[ENTRY_W-1:TAG_BITS];
  assign pop_tag   = rd_word[TAG_BITS-1:0];

  tchd_back #(.TAG_BITS(TAG_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_entry (pop_entry),
    .q_tag   (pop_tag),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .st      (st)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st.pop |-> !q_empty)
    else $error("queue read while empty");

  a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st.rel |=> st.busy)
    else $error("released group not sequenced");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!st.busy && out_ch.ready) |=> !out_ch.valid)
    else $error("result transaction without a released group");
`endif

endmodule
